>>> hw/rtl/cmfc_pkg.sv
package cmfc_pkg;

   // Field widths
   localparam int DATA_W      = 8;
   localparam int CRC_W       = 32;
   localparam int CK_OFFSET_W = 12;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // CRC32C, reflected form
   localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

   // Checksum field is four bytes wide
   localparam int FIELD_BYTES = 4;
   localparam int LANE_W      = $clog2(FIELD_BYTES);

   // Default structure size limit for the position counter
   localparam int MAX_STRUCT_BYTES_DEF = 4096;

   // Register map (word index taken from paddr[2])
   localparam logic [CK_OFFSET_W-1:0] CK_OFFSET_RESET = 12'd252;
   localparam logic                   REG_CK_OFFSET   = 1'b0;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              first_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic [CRC_W-1:0] crc_value;
      logic [CRC_W-1:0] stored_value;
      logic             checksum_match;
   } rsp_item_type;

   // Per-cycle step control from the top to the core and result stage
   typedef struct packed {
      logic fire;  // input stage hands its item to the core this cycle
      logic emit;  // that item is a last byte and loads the result register
   } step_ctl_type;

   // One byte of reflected CRC32C, eight shift steps
   function automatic logic [CRC_W-1:0] crc_byte_step(input logic [CRC_W-1:0] crc,
                                                      input logic [DATA_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-DATA_W){1'b0}}, data};
      for (int k = 0; k < DATA_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/cmfc_csr.sv
module cmfc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cmfc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cmfc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cmfc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [cmfc_pkg::CK_OFFSET_W-1:0]    ck_offset
);

   logic [cmfc_pkg::CK_OFFSET_W-1:0] ck_offset_ff;
   logic [cmfc_pkg::CK_OFFSET_W-1:0] ck_offset_in;
   logic                             sel_ck_offset;

   assign sel_ck_offset = (paddr[2] == cmfc_pkg::REG_CK_OFFSET);

   // Write in the access phase
   always_comb begin
      ck_offset_in = ck_offset_ff;
      if (psel && penable && pwrite && sel_ck_offset) begin
         ck_offset_in = pwdata[cmfc_pkg::CK_OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ck_offset_ff <= cmfc_pkg::CK_OFFSET_RESET;
      end else begin
         ck_offset_ff <= ck_offset_in;
      end
   end

   // Read back; unmapped word reads zero
   assign prdata = sel_ck_offset ?
                   {{(cmfc_pkg::CSR_DATA_W-cmfc_pkg::CK_OFFSET_W){1'b0}}, ck_offset_ff} :
                   '0;
   assign pready    = 1'b1;
   assign ck_offset = ck_offset_ff;

endmodule

>>> hw/rtl/cmfc_in_stage.sv
module cmfc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cmfc_pkg::req_item_type req_data,
   input  logic                  fire,
   output logic                  item_valid,
   output cmfc_pkg::req_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   cmfc_pkg::req_item_type item_ff;
   logic                   accept;

   // Slot frees up in the same cycle the core takes the held item
   assign req_ready = !valid_ff || fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/cmfc_core.sv
module cmfc_core #(
   parameter int MAX_STRUCT_BYTES = cmfc_pkg::MAX_STRUCT_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cmfc_pkg::step_ctl_type           ctl,
   input  cmfc_pkg::req_item_type           item,
   input  logic [cmfc_pkg::CK_OFFSET_W-1:0] ck_offset,
   output cmfc_pkg::rsp_item_type           result
);

   localparam int PW = $clog2(MAX_STRUCT_BYTES);
   localparam int CW = ((PW > cmfc_pkg::CK_OFFSET_W) ? PW : cmfc_pkg::CK_OFFSET_W) + 1;
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_STRUCT_BYTES - 1);

   logic [cmfc_pkg::CRC_W-1:0] crc_ff, crc_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [cmfc_pkg::CRC_W-1:0] cap_ff, cap_in;

   logic [cmfc_pkg::CRC_W-1:0]  crc_base, crc_next, cap_base, cap_new;
   logic [PW-1:0]               pos_eff, pos_inc;
   logic [CW-1:0]               pos_w, off_w, rel_w;
   logic                        in_field;
   logic [cmfc_pkg::LANE_W-1:0] lane;
   logic [cmfc_pkg::DATA_W-1:0] fed;

   // A first mark restarts the structure before this byte
   assign crc_base = item.first_byte ? cmfc_pkg::CRC_INIT : crc_ff;
   assign cap_base = item.first_byte ? '0 : cap_ff;
   assign pos_eff  = item.first_byte ? '0 : pos_ff;

   // Checksum window, compared without wrap
   assign pos_w    = CW'(pos_eff);
   assign off_w    = CW'(ck_offset);
   assign rel_w    = pos_w - off_w;
   assign in_field = (pos_w >= off_w) && (pos_w < off_w + CW'(cmfc_pkg::FIELD_BYTES));
   assign lane     = rel_w[cmfc_pkg::LANE_W-1:0];

   // Capture the field byte little-endian
   always_comb begin
      cap_new = cap_base;
      if (in_field) begin
         unique case (lane)
            2'd0: cap_new[7:0]   = item.data_byte;
            2'd1: cap_new[15:8]  = item.data_byte;
            2'd2: cap_new[23:16] = item.data_byte;
            2'd3: cap_new[31:24] = item.data_byte;
            default: cap_new = cap_base;
         endcase
      end
   end

   assign fed      = in_field ? '0 : item.data_byte;
   assign crc_next = cmfc_pkg::crc_byte_step(crc_base, fed);
   assign pos_inc  = (pos_eff < POS_MAX) ? pos_eff + PW'(1) : pos_eff;

   // State update; a last byte returns to start values
   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      cap_in = cap_ff;
      if (ctl.fire) begin
         if (item.last_byte) begin
            crc_in = cmfc_pkg::CRC_INIT;
            pos_in = '0;
            cap_in = '0;
         end else begin
            crc_in = crc_next;
            pos_in = pos_inc;
            cap_in = cap_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= cmfc_pkg::CRC_INIT;
         pos_ff <= '0;
         cap_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         cap_ff <= cap_in;
      end
   end

   // Final result for a last byte
   assign result.crc_value      = ~crc_next;
   assign result.stored_value   = cap_new;
   assign result.checksum_match = (~crc_next == cap_new);

endmodule

>>> hw/rtl/cmfc_out_stage.sv
module cmfc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  cmfc_pkg::step_ctl_type ctl,
   input  cmfc_pkg::rsp_item_type result,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cmfc_pkg::rsp_item_type rsp_data
);

   logic                   valid_ff;
   logic                   valid_in;
   cmfc_pkg::rsp_item_type data_ff;

   // Emit is only raised when the register is free or being drained
   always_comb begin
      valid_in = valid_ff;
      if (ctl.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> hw/rtl/crc32c_masked_field_checker_top.sv
// CRC32C checker for a metadata structure with an embedded checksum field.
// Input channel (req_): one byte per item with first/last marks. A first
// mark restarts the CRC, byte position and captured field; after a last
// byte the block also restarts on its own.
// The four bytes at ck_offset enter the CRC as zero and are captured
// little-endian as the stored checksum.
// Result channel (rsp_): one item per last byte with the inverted CRC, the
// stored value and a match flag. Non-last bytes give no result.
// Throughput: one byte per cycle unless a last byte waits on a held result.
// An accepted byte sits in the input register, the CRC byte update is
// combinational, and a last byte then loads the result register.
// When rsp_ready is low the result register holds; bytes that are not last
// keep flowing, and a following last byte waits in the input register,
// which drops req_ready until the result is taken.
// Reset: synchronous; CRC state restarts, ck_offset returns to 252, both
// channels go empty. The user must write configuration (APB, pready always
// high) only while no structure is in flight; the block does not check it.
module crc32c_masked_field_checker_top #(
   parameter int MAX_STRUCT_BYTES = cmfc_pkg::MAX_STRUCT_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cmfc_pkg::req_item_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cmfc_pkg::rsp_item_type          rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cmfc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cmfc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cmfc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic [cmfc_pkg::CK_OFFSET_W-1:0] ck_offset;
   logic                             item_valid;
   cmfc_pkg::req_item_type           item;
   cmfc_pkg::rsp_item_type           result;
   cmfc_pkg::step_ctl_type           ctl;

   cmfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .ck_offset (ck_offset)
   );

   cmfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .fire       (ctl.fire),
      .item_valid (item_valid),
      .item       (item)
   );

   // Held item advances unless it is a last byte and the result register is stuck
   assign ctl.fire = item_valid && (!item.last_byte || !rsp_valid || rsp_ready);
   assign ctl.emit = ctl.fire && item.last_byte;

   cmfc_core #(
      .MAX_STRUCT_BYTES (MAX_STRUCT_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (item),
      .ck_offset (ck_offset),
      .result    (result)
   );

   cmfc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/cmfc_checker.sv
module cmfc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cmfc_pkg::rsp_item_type rsp_data,
   input logic                   pready
);

   // Results are cleared by reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Match flag agrees with the two values it compares
   a_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.checksum_match ==
                     (rsp_data.crc_value == rsp_data.stored_value)))
      else $error("match flag inconsistent");

   // Input only backs up when a result is pending
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind crc32c_masked_field_checker_top cmfc_checker u_cmfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

>>> dv/tb_crc32c_masked_field_checker_top.sv
`timescale 1ns / 1ps

module tb_crc32c_masked_field_checker_top;

   // Register address of ck_offset (word 0)
   localparam logic [cmfc_pkg::CSR_ADDR_W-1:0] CK_OFFSET_ADDR =
      {cmfc_pkg::REG_CK_OFFSET, 2'b00};
   localparam int unsigned LAST_POSITION = cmfc_pkg::MAX_STRUCT_BYTES_DEF - 1;

   // Expected CRC results, built from accepted bytes
   class crc_scoreboard;
      localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;
      localparam logic [31:0] CRC_SEED        = 32'hFFFF_FFFF;

      logic [31:0]            crc_state = CRC_SEED;
      int unsigned            position = 0;
      logic [31:0]            stored_field = '0;
      logic [11:0]            ck_offset = cmfc_pkg::CK_OFFSET_RESET;
      cmfc_pkg::rsp_item_type expected_q[$];
      int unsigned            mismatches = 0;
      int unsigned            results_seen = 0;
      int unsigned            matches_seen = 0;

      // One reflected CRC32C byte update, one bit per step
      static function logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] d);
         logic [31:0] r;
         r = c ^ {24'd0, d};
         repeat (8) r = (r >> 1) ^ (CASTAGNOLI_POLY & {32{r[0]}});
         return r;
      endfunction

      function void restart();
         crc_state    = CRC_SEED;
         position     = 0;
         stored_field = '0;
      endfunction

      function void note_byte(cmfc_pkg::req_item_type it);
         logic [7:0]             fed;
         int unsigned            lane;
         cmfc_pkg::rsp_item_type res;
         if (it.first_byte) restart();
         fed = it.data_byte;
         // checksum window, no wrap past the top position
         if (position >= ck_offset && position < ck_offset + 4) begin
            lane = position - ck_offset;
            stored_field[lane*8 +: 8] = it.data_byte;
            fed = 8'd0;
         end
         crc_state = crc32c_step(crc_state, fed);
         if (position < LAST_POSITION) position++;
         if (it.last_byte) begin
            res.crc_value      = ~crc_state;
            res.stored_value   = stored_field;
            res.checksum_match = (~crc_state == stored_field);
            expected_q.push_back(res);
            restart();
         end
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t ERROR %s: got %h, expected %h", $time, what, got, want);
         mismatches++;
      endtask

      task check_result(cmfc_pkg::rsp_item_type got);
         cmfc_pkg::rsp_item_type want;
         if (expected_q.size() == 0) begin
            report("result with none pending, crc_value", got.crc_value, 32'd0);
            return;
         end
         want = expected_q.pop_front();
         results_seen++;
         if (want.checksum_match) matches_seen++;
         if (got.crc_value !== want.crc_value)
            report("crc_value", got.crc_value, want.crc_value);
         if (got.stored_value !== want.stored_value)
            report("stored_value", got.stored_value, want.stored_value);
         if (got.checksum_match !== want.checksum_match)
            report("checksum_match", 32'(got.checksum_match), 32'(want.checksum_match));
      endtask
   endclass

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   cmfc_pkg::req_item_type              req_data;
   logic                                rsp_valid;
   logic                                rsp_ready;
   cmfc_pkg::rsp_item_type              rsp_data;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [cmfc_pkg::CSR_ADDR_W-1:0]     paddr;
   logic [cmfc_pkg::CSR_DATA_W-1:0]     pwdata;
   logic [cmfc_pkg::CSR_DATA_W-1:0]     prdata;
   logic                                pready;

   crc_scoreboard sb = new;

   int unsigned burst_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned structs_sent = 0;
   int unsigned longest = 0;
   int unsigned offset_writes = 0;
   int unsigned rx_cycle = 0;
   int unsigned rx_hold = 0;

   crc32c_masked_field_checker_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   // Result side: open, coin-flip and long-stall stretches in turn
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_mode_type'(2'((rx_cycle / 97) % 3)))
         RX_OPEN: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            if (rx_hold == 0) begin
               rx_hold   <= $urandom_range(1, 15);
               rsp_ready <= ~rsp_ready;
            end else begin
               rx_hold <= rx_hold - 1;
            end
         end
      endcase
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // Called and returns at a falling edge; valid stays high until the next call
   task automatic push_byte(logic [7:0] d, logic first, logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid            = 1'b1;
      req_data.data_byte   = d;
      req_data.first_byte  = first;
      req_data.last_byte   = last;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(req_data);
      bytes_sent++;
      @(negedge clock);
   endtask

   // One structure; a good one carries the correct checksum in its field
   task automatic send_struct(int unsigned len, bit good, bit with_first);
      logic [7:0]  body[$];
      logic [31:0] c;
      int unsigned off;
      off = sb.ck_offset;
      for (int i = 0; i < len; i++) body.push_back(8'($urandom));
      if (good && off + 4 <= len) begin
         c = crc_scoreboard::CRC_SEED;
         for (int i = 0; i < len; i++)
            c = crc_scoreboard::crc32c_step(c, (i >= off && i < off + 4) ? 8'd0 : body[i]);
         c = ~c;
         for (int k = 0; k < 4; k++) body[off + k] = c[k*8 +: 8];
      end
      for (int i = 0; i < len; i++)
         push_byte(body[i], with_first && i == 0, i == len - 1);
      structs_sent++;
      if (len > longest) longest = len;
   endtask

   // Broken checksum: one flipped bit somewhere in a good structure
   task automatic send_bad_struct(int unsigned len);
      logic [7:0]  body[$];
      logic [31:0] c;
      int unsigned off;
      int unsigned hit;
      off = sb.ck_offset;
      for (int i = 0; i < len; i++) body.push_back(8'($urandom));
      c = crc_scoreboard::CRC_SEED;
      for (int i = 0; i < len; i++)
         c = crc_scoreboard::crc32c_step(c, (i >= off && i < off + 4) ? 8'd0 : body[i]);
      c = ~c;
      for (int k = 0; k < 4; k++) if (off + k < len) body[off + k] = c[k*8 +: 8];
      hit = $urandom_range(0, len - 1);
      body[hit] = body[hit] ^ (8'd1 << $urandom_range(0, 7));
      for (int i = 0; i < len; i++) push_byte(body[i], i == 0, i == len - 1);
      structs_sent++;
   endtask

   // Let everything drain so the block is idle
   task automatic wait_quiet();
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write followed by a read-back
   task automatic csr_write(logic [11:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CK_OFFSET_ADDR;
      pwdata  = {20'd0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.ck_offset = value;
      offset_writes++;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[11:0] !== value) sb.report("ck_offset read-back", prdata, {20'd0, value});
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Mostly well-formed structures, some broken ones and loose noise
   task automatic random_phase(int unsigned budget);
      int unsigned start;
      int unsigned kind;
      int unsigned off;
      start = bytes_sent;
      off   = sb.ck_offset;
      while (bytes_sent - start < budget) begin
         kind = $urandom_range(0, 99);
         if (off > 40 && kind < 80) kind = 94 + kind % 6;
         if (kind < 60) begin
            send_struct(off + 4 + $urandom_range(0, 14), 1'b1, $urandom_range(0, 3) != 0);
         end else if (kind < 72) begin
            send_bad_struct(off + 4 + $urandom_range(0, 10));
         end else if (kind < 80) begin
            // structure ends inside the checksum field
            send_struct(off + $urandom_range(1, 3), 1'b0, 1'b1);
         end else if (kind < 88) begin
            // abandoned fragment, then a restart by a first mark
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'($urandom), 1'b0);
            send_struct($urandom_range(1, 20), 1'b0, 1'b1);
         end else if (kind < 92) begin
            push_byte(8'($urandom), 1'b1, 1'b1);
         end else if (kind < 95) begin
            repeat ($urandom_range(1, 8))
               push_byte(8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            send_struct($urandom_range(1, 24), 1'($urandom), 1'($urandom));
         end
      end
      send_struct($urandom_range(1, 8), 1'b0, 1'b1);
   endtask

   initial begin
      #(20_000_000);
      $display("crc32c_masked_field_checker_top: mismatch");
      $finish;
   end

   initial begin
      int unsigned phase_offsets[$];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset offset: one-byte and short structures, restart without a first mark
      push_byte(8'h00, 1'b1, 1'b1);
      push_byte(8'hFF, 1'b1, 1'b1);
      push_byte(8'h5A, 1'b0, 1'b1);
      push_byte(8'h01, 1'b1, 1'b0);
      push_byte(8'h80, 1'b0, 1'b0);
      push_byte(8'hFE, 1'b0, 1'b1);
      push_byte(8'h33, 1'b1, 1'b0);
      push_byte(8'hC3, 1'b1, 1'b0);
      push_byte(8'h3C, 1'b0, 1'b1);
      wait_quiet();

      // Directed, field at offset zero
      csr_write(12'd0);
      send_struct(4, 1'b1, 1'b1);
      send_struct(7, 1'b1, 1'b0);
      send_bad_struct(5);
      random_phase(260);

      phase_offsets = '{12'hFFF, 12'd4093, $urandom_range(1, 40), $urandom_range(1, 40),
                        12'h555, $urandom_range(1, 40), 12'd252};
      foreach (phase_offsets[i]) begin
         wait_quiet();
         csr_write(12'(phase_offsets[i]));
         random_phase(215);
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      while (sb.expected_q.size() != 0) begin
         sb.report("missing result, crc_value", 32'd0, sb.expected_q[0].crc_value);
         void'(sb.expected_q.pop_front());
      end
      $display("sent %0d bytes in %0d structures (longest %0d) over %0d offset settings",
               bytes_sent, structs_sent, longest, offset_writes + 1);
      $display("checked %0d results, %0d with a matching checksum, %0d errors",
               sb.results_seen, sb.matches_seen, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("crc32c_masked_field_checker_top: match");
      end else begin
         $display("crc32c_masked_field_checker_top: mismatch");
      end
      $finish;
   end

endmodule
